### rtl/core/aes_pkg.sv
// AES-128 package: S-box table, GF(2^8) helpers and round function.
// No dependencies; used by aes_round, aes128_block_encrypt_top, the checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int ROUNDS = 10;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] GF_POLY = 8'h1B;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // Byte i of a 128-bit word sits at bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        get_byte = w[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4)*4 + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, c*4);
            a1  = get_byte(s, c*4 + 1);
            a2  = get_byte(s, c*4 + 2);
            a3  = get_byte(s, c*4 + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 32] = {a0 ^ all ^ gf_dbl(a0 ^ a1), a1 ^ all ^ gf_dbl(a1 ^ a2),
                                   a2 ^ all ^ gf_dbl(a2 ^ a3), a3 ^ all ^ gf_dbl(a3 ^ a0)};
        end
        mix_cols = t;
    endfunction

endpackage
`default_nettype wire

### rtl/core/aes_round.sv
// One registered AES round stage with its key-expansion step.
// Depends on aes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic         i_final,
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_key,
    input  wire logic [7:0]   i_rc,
    input  wire logic         i_last,
    output logic              o_valid,
    output logic [127:0]      o_state,
    output logic [127:0]      o_key,
    output logic [7:0]        o_rc,
    output logic              o_last
);
    logic [127:0] n_key, n_sub, n_state;

    always_comb begin
        n_key   = next_key(i_key, i_rc);
        n_sub   = sub_shift(i_state);
        n_state = (i_final ? n_sub : mix_cols(n_sub)) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_state <= n_state;
        o_key   <= n_key;
        o_rc    <= gf_dbl(i_rc);
        o_last  <= i_last;
    end
endmodule
`default_nettype wire

### rtl/core/aes128_block_encrypt_top.sv
// AES-128 ECB encryptor top level: key registers, key addition, ten round stages.
// Depends on aes_pkg and aes_round.
//
// Channel   Dir  Handshake             Payload
// input     in   i_start / o_busy      i_plain_high, i_plain_low, i_last_block
// result    out  o_done (strobe)       o_cipher_high, o_cipher_low, o_last_out
// config    in   i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// From accepted start to o_done: one key-addition stage, then one register per
// round. One block enters every cycle; o_busy is always low since the receiver
// cannot stall and the pipeline never backs up.
// Reset clears the valid bits and the key registers to zero.
// Round keys are expanded alongside the data, so a key change applies to
// blocks accepted after the write.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_encrypt_top
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [63:0] i_plain_high,
    input  wire logic [63:0] i_plain_low,
    input  wire logic        i_last_block,
    output logic             o_done,
    output logic [63:0]      o_cipher_high,
    output logic [63:0]      o_cipher_low,
    output logic             o_last_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_key_high, r_key_low;

    // Stage arrays: index 0 is the key-addition register, 1..ROUNDS the rounds.
    logic         r_stg_valid [0:ROUNDS];
    logic [127:0] r_stg_state [0:ROUNDS];
    logic [127:0] r_stg_key   [0:ROUNDS];
    logic [7:0]   r_stg_rc    [0:ROUNDS];
    logic         r_stg_last  [0:ROUNDS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Key registers; a write to any other index is dropped (index is one bit).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Initial AddRoundKey stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid[0] <= 1'b0;
        end else begin
            r_stg_valid[0] <= i_start;
        end
        r_stg_state[0] <= {i_plain_high, i_plain_low} ^ {r_key_high, r_key_low};
        r_stg_key[0]   <= {r_key_high, r_key_low};
        r_stg_rc[0]    <= RCON_FIRST;
        r_stg_last[0]  <= i_last_block;
    end

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_stg_valid[g-1]),
            .i_final ((g == ROUNDS) ? 1'b1 : 1'b0),
            .i_state (r_stg_state[g-1]),
            .i_key   (r_stg_key[g-1]),
            .i_rc    (r_stg_rc[g-1]),
            .i_last  (r_stg_last[g-1]),
            .o_valid (r_stg_valid[g]),
            .o_state (r_stg_state[g]),
            .o_key   (r_stg_key[g]),
            .o_rc    (r_stg_rc[g]),
            .o_last  (r_stg_last[g])
        );
    end

    assign o_done        = r_stg_valid[ROUNDS];
    assign o_cipher_high = r_stg_state[ROUNDS][127:64];
    assign o_cipher_low  = r_stg_state[ROUNDS][63:0];
    assign o_last_out    = r_stg_last[ROUNDS];
endmodule
`default_nettype wire

### tb/sv/aes128_block_encrypt_checker.sv
// Checker for the AES-128 ECB encryptor: tracks key writes and accepted blocks,
// predicts each ciphertext and compares it with the result strobe. Depends on aes_pkg.
`timescale 1ns / 1ps
module aes128_block_encrypt_checker
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [63:0] i_plain_high,
    input  wire logic [63:0] i_plain_low,
    input  wire logic        i_last_block,
    input  wire logic        i_done,
    input  wire logic [63:0] i_cipher_high,
    input  wire logic [63:0] i_cipher_low,
    input  wire logic        i_last_out,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } t_cipher;

    logic [127:0] key_q;
    t_cipher      cipher_q[$];

    // GF(2^8) doubling, reduction polynomial 0x11b.
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                   input logic [127:0] key);
        logic [127:0] s, k, t;
        logic [31:0]  w;
        logic [7:0]   rc, a0, a1, a2, a3, all;
        s  = pt ^ key;
        k  = key;
        rc = 8'h01;
        for (int r = 1; r <= ROUNDS; r++) begin
            w = {SBOX[byte_at(k, 13)] ^ rc, SBOX[byte_at(k, 14)],
                 SBOX[byte_at(k, 15)], SBOX[byte_at(k, 12)]};
            k[127:96] = k[127:96] ^ w;
            k[95:64]  = k[95:64] ^ k[127:96];
            k[63:32]  = k[63:32] ^ k[95:64];
            k[31:0]   = k[31:0] ^ k[63:32];
            rc = xtime(rc);
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[127 - 8*(c*4 + row) -: 8] = SBOX[byte_at(s, ((c + row) % 4)*4 + row)];
            s = t;
            if (r < ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0  = byte_at(s, c*4);
                    a1  = byte_at(s, c*4 + 1);
                    a2  = byte_at(s, c*4 + 2);
                    a3  = byte_at(s, c*4 + 3);
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                           a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
                end
            end
            s = s ^ k;
        end
        return s;
    endfunction

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        t_cipher      exp_c;
        logic [127:0] ct;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            key_q <= '0;
            cipher_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_done) begin
                if (cipher_q.size() == 0) begin
                    $error("result with no block outstanding");
                    errs++;
                end else begin
                    exp_c = cipher_q.pop_front();
                    if (exp_c.hi !== i_cipher_high) begin
                        $error("cipher_high exp %h got %h", exp_c.hi, i_cipher_high);
                        errs++;
                    end
                    if (exp_c.lo !== i_cipher_low) begin
                        $error("cipher_low exp %h got %h", exp_c.lo, i_cipher_low);
                        errs++;
                    end
                    if (exp_c.last !== i_last_out) begin
                        $error("last_out exp %b got %b", exp_c.last, i_last_out);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            // a block transfer uses the key in force before a same-edge write
            if (i_start && !i_busy) begin
                ct = encrypt_block({i_plain_high, i_plain_low}, key_q);
                cipher_q.push_back('{ct[127:64], ct[63:0], i_last_block});
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_KEY_HIGH) key_q[127:64] <= i_cfg_data;
                else key_q[63:0] <= i_cfg_data;
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for aes128_block_encrypt_top: clock, reset, key and block stimulus.
// Depends on aes_pkg, the block and aes128_block_encrypt_checker.
`timescale 1ns / 1ps
module tb_top
    import aes_pkg::*;
;

    localparam int PIPE_CYCLES = 11;

    logic        clk, rst_n;
    logic        start, busy, last_block, done, last_out;
    logic [63:0] plain_high, plain_low, cipher_high, cipher_low;
    logic        cfg_valid, cfg_ready;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count, pending;
    int          n_blocks, n_keys;

    always begin
        clk = 1'b1; #6;
        clk = 1'b0; #6;
    end

    aes128_block_encrypt_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_plain_high(plain_high), .i_plain_low(plain_low), .i_last_block(last_block),
        .o_done(done), .o_cipher_high(cipher_high), .o_cipher_low(cipher_low),
        .o_last_out(last_out), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    aes128_block_encrypt_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_plain_high(plain_high), .i_plain_low(plain_low), .i_last_block(last_block),
        .i_done(done), .i_cipher_high(cipher_high), .i_cipher_low(cipher_low),
        .i_last_out(last_out), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Wait for the pipeline to drain so a key write lands while idle.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (PIPE_CYCLES + 2) @(posedge clk);
    endtask

    task automatic write_key(input logic [0:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_keys++;
    endtask

    // One block transfer; idle_pct sets the chance of a gap cycle first.
    // start stays high across back-to-back blocks.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic last, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        plain_high <= hi;
        plain_low  <= lo;
        last_block <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        n_blocks++;
    endtask

    task automatic idle_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Random blocks; mixes full-random data with sparse and extreme patterns.
    task automatic random_blocks(input int count, input int idle_pct);
        logic [63:0] hi, lo;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0: begin hi = '1; lo = '0; end
                1: begin hi = 64'd1 << $urandom_range(63); lo = ~(64'd1 << $urandom_range(63)); end
                default: begin hi = rand64(); lo = rand64(); end
            endcase
            send_block(hi, lo, 1'($urandom_range(1)), idle_pct);
        end
        idle_start();
    endtask

    initial begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        plain_high <= '0;
        plain_low  <= '0;
        last_block <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_KEY_HIGH;
        cfg_data   <= '0;
        n_blocks = 0;
        n_keys   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero key after reset, extreme plaintexts, last flag both ways.
        send_block('0, '0, 1'b0, 0);
        send_block('1, '1, 1'b1, 0);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0, 0);
        idle_start();
        drain();

        // Standard test vector key 000102..0f, plaintext 00112233..ff.
        write_key(CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
        write_key(CFG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1, 0);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 0);
        idle_start();
        drain();

        // All-ones key, then a key change taking effect for following blocks.
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        send_block('0, '1, 1'b0, 0);
        send_block('1, '0, 1'b1, 0);
        idle_start();
        drain();
        write_key(CFG_KEY_LOW, '0);
        send_block('1, '1, 1'b0, 0);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1, 0);
        idle_start();
        drain();

        // Random phases: sender idles 17%, then 75%, then never; fresh key each.
        for (int ph = 0; ph < 9; ph++) begin
            write_key(CFG_KEY_HIGH, rand64());
            write_key(CFG_KEY_LOW, rand64());
            random_blocks(150, (ph < 3) ? 17 : (ph < 6) ? 75 : 0);
            drain();
        end

        drain();
        $display("Covered %0d blocks under %0d key writes, zero/ones/random keys,",
                 n_blocks, n_keys);
        $display("with sender gaps at 17%%, 75%% and none, full drains between keys.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### aes128_block_encrypt_top.f
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_encrypt_top.sv
tb/sv/aes128_block_encrypt_checker.sv
tb/sv/tb_top.sv
